@@ hdl/obpa_pkg.sv @@
// obpa_pkg: shared types and constants for the bin packing allocator
// no dependencies
`timescale 1ns / 1ps

package obpa_pkg;

  localparam int MAX_BINS_DEF = 256;
  localparam int WEIGHT_W     = 16;
  localparam int BIN_W        = 8;
  localparam int COUNT_W      = 9;
  localparam int STATUS_W     = 2;
  localparam int MODE_W       = 2;

  localparam logic [WEIGHT_W-1:0] CAP_RESET = 16'd10;

  typedef enum logic [MODE_W-1:0] {
    MODE_NEXT  = 2'd0,
    MODE_FIRST = 2'd1,
    MODE_BEST  = 2'd2,
    MODE_WORST = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_OVER = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_WRITE
  } state_t;

  typedef enum logic {
    REG_CAPACITY = 1'b0,
    REG_MODE     = 1'b1
  } reg_t;

endpackage

@@ hdl/obpa_ram.sv @@
// obpa_ram: generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module obpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/online_bin_packing_allocator.sv @@
// online_bin_packing_allocator: top level, sequencer, compare unit and apb registers
// depends on obpa_pkg and obpa_ram
// done is registered after eval for an overweight item, after write with no open bin,
// and after the scan and write when bins are read (next fit reads one, first fit stops at its hit)
// the scan reads one bin per cycle from the room ram, up to MAX_BINS bins for an item
// busy stays high for the whole item; the receiver cannot stall done
// reset: capacity 10, first fit, no bins open; the ram needs no clearing pass
`timescale 1ns / 1ps

module online_bin_packing_allocator #(
  parameter int MAX_BINS = obpa_pkg::MAX_BINS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [obpa_pkg::WEIGHT_W-1:0]   item_weight,
  input  logic                            new_set,
  output logic                            done,
  output logic [obpa_pkg::BIN_W-1:0]      placed_bin,
  output logic                            opened_new,
  output logic [obpa_pkg::COUNT_W-1:0]    bins_used,
  output logic [obpa_pkg::STATUS_W-1:0]   status,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int IDX_W = $clog2(MAX_BINS);
  localparam int CNT_W = $clog2(MAX_BINS + 1);
  localparam int WW    = obpa_pkg::WEIGHT_W;

  obpa_pkg::state_t  state, state_next;
  obpa_pkg::mode_t   fit_mode;
  obpa_pkg::status_t res_status;

  logic [WW-1:0]    bin_capacity;
  logic [CNT_W-1:0] open_count;
  logic [WW-1:0]    item_w;
  logic [CNT_W-1:0] iss;
  logic             rd_valid;
  logic [IDX_W-1:0] rd_idx;
  logic             have_pick;
  logic [IDX_W-1:0] pick_idx;
  logic [WW-1:0]    pick_room;
  logic [obpa_pkg::BIN_W-1:0]   res_bin;
  logic                         res_opened;
  logic [obpa_pkg::COUNT_W-1:0] res_count;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [WW-1:0]    mem_wdata;
  logic [WW-1:0]    mem_rdata;

  logic             over, full, first_hit, scan_done;
  logic             issue, take, res_load, cnt_inc;
  logic [WW-1:0]    after;
  logic             fits;
  logic [obpa_pkg::BIN_W-1:0] ld_bin;
  logic             ld_opened;
  obpa_pkg::status_t ld_status;
  logic             accept, cfg_wr;

  assign accept    = start && !busy;
  assign busy      = (state != obpa_pkg::ST_IDLE);
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign over      = item_w > bin_capacity;
  assign full      = (open_count == CNT_W'(MAX_BINS));
  assign first_hit = have_pick && (fit_mode == obpa_pkg::MODE_FIRST);
  assign scan_done = !rd_valid && ((iss == open_count) || first_hit);
  assign fits      = mem_rdata >= item_w;
  assign after     = mem_rdata - item_w;

  obpa_ram #(
    .WIDTH(WW),
    .DEPTH(MAX_BINS)
  ) u_room (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (iss[IDX_W-1:0]),
    .rdata (mem_rdata)
  );

  always_comb begin
    unique case (obpa_pkg::reg_t'(paddr[2]))
      obpa_pkg::REG_CAPACITY: prdata = {16'd0, bin_capacity};
      obpa_pkg::REG_MODE:     prdata = {30'd0, fit_mode};
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      obpa_pkg::ST_IDLE: begin
        if (accept) state_next = obpa_pkg::ST_EVAL;
      end
      obpa_pkg::ST_EVAL: begin
        if (over) begin
          state_next = obpa_pkg::ST_IDLE;
        end else if (open_count == '0) begin
          state_next = obpa_pkg::ST_WRITE;
        end else begin
          state_next = obpa_pkg::ST_SCAN;
        end
      end
      obpa_pkg::ST_SCAN: begin
        if (scan_done) state_next = obpa_pkg::ST_WRITE;
      end
      obpa_pkg::ST_WRITE: state_next = obpa_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    issue     = 1'b0;
    take      = 1'b0;
    res_load  = 1'b0;
    cnt_inc   = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = pick_idx;
    mem_wdata = pick_room;
    ld_bin    = '0;
    ld_opened = 1'b0;
    ld_status = obpa_pkg::STAT_OK;
    unique case (state)
      obpa_pkg::ST_IDLE: ;
      obpa_pkg::ST_EVAL: begin
        if (over) begin
          res_load  = 1'b1;
          ld_status = obpa_pkg::STAT_OVER;
        end
      end
      obpa_pkg::ST_SCAN: begin
        take = rd_valid && fits &&
               (!have_pick ||
                ((fit_mode == obpa_pkg::MODE_BEST) && (after < pick_room)) ||
                ((fit_mode == obpa_pkg::MODE_WORST) && (after > pick_room)));
        issue = (iss != open_count) && !first_hit &&
                !(take && (fit_mode == obpa_pkg::MODE_FIRST));
      end
      obpa_pkg::ST_WRITE: begin
        res_load = 1'b1;
        if (have_pick) begin
          mem_we = 1'b1;
          ld_bin = obpa_pkg::BIN_W'(pick_idx);
        end else if (full) begin
          ld_status = obpa_pkg::STAT_FULL;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = open_count[IDX_W-1:0];
          mem_wdata = bin_capacity - item_w;
          ld_bin    = obpa_pkg::BIN_W'(open_count);
          ld_opened = 1'b1;
          cnt_inc   = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= obpa_pkg::ST_IDLE;
      bin_capacity <= obpa_pkg::CAP_RESET;
      fit_mode     <= obpa_pkg::MODE_FIRST;
      open_count   <= '0;
      rd_valid     <= 1'b0;
      have_pick    <= 1'b0;
      done         <= 1'b0;
    end else begin
      state <= state_next;
      done  <= res_load;
      if (cfg_wr) begin
        case (obpa_pkg::reg_t'(paddr[2]))
          obpa_pkg::REG_CAPACITY: bin_capacity <= pwdata[WW-1:0];
          obpa_pkg::REG_MODE:     fit_mode     <= obpa_pkg::mode_t'(pwdata[1:0]);
          default: ;
        endcase
      end
      if (accept && new_set) begin
        open_count <= '0;
      end else if (cnt_inc) begin
        open_count <= open_count + 1'b1;
      end
      if (state == obpa_pkg::ST_EVAL) begin
        have_pick <= 1'b0;
        rd_valid  <= 1'b0;
      end else begin
        rd_valid <= issue;
        if (take) have_pick <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item_w <= item_weight;
    if (state == obpa_pkg::ST_EVAL) begin
      iss <= (fit_mode == obpa_pkg::MODE_NEXT) ? open_count - 1'b1 : '0;
    end else if (issue) begin
      iss <= iss + 1'b1;
    end
    rd_idx <= iss[IDX_W-1:0];
    if (take) begin
      pick_idx  <= rd_idx;
      pick_room <= after;
    end
    if (res_load) begin
      res_bin    <= ld_bin;
      res_opened <= ld_opened;
      res_status <= ld_status;
      res_count  <= cnt_inc ? obpa_pkg::COUNT_W'(open_count + 1'b1)
                            : obpa_pkg::COUNT_W'(open_count);
    end
  end

  assign placed_bin = res_bin;
  assign opened_new = res_opened;
  assign bins_used  = res_count;
  assign status     = res_status;

endmodule

@@ hdl/obpa_checker.sv @@
// obpa_checker: port level assertions for the bin packing allocator, bound to the top
// depends on obpa_pkg and online_bin_packing_allocator
`timescale 1ns / 1ps

module obpa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [obpa_pkg::BIN_W-1:0]    placed_bin,
  input logic                          opened_new,
  input logic [obpa_pkg::COUNT_W-1:0]  bins_used,
  input logic [obpa_pkg::STATUS_W-1:0] status
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("done outside the end of an item");

  a_reject_fields: assert property (@(posedge clk) disable iff (rst)
    done && (status != obpa_pkg::STAT_OK) |-> !opened_new && (placed_bin == '0))
    else $error("rejected item reports a placement");

  a_open_counts: assert property (@(posedge clk) disable iff (rst)
    done && opened_new |-> (status == obpa_pkg::STAT_OK) && (bins_used != '0))
    else $error("new bin without a count");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == obpa_pkg::STAT_OK) || (status == obpa_pkg::STAT_OVER) ||
             (status == obpa_pkg::STAT_FULL))
    else $error("bad status code");

endmodule

bind online_bin_packing_allocator obpa_checker u_obpa_checker (.*);

@@ tb/tb_top.sv @@
// tb_top: self-checking bench for online_bin_packing_allocator, with a placement predictor
// and scoreboard class, apb register writes and random item bursts
// depends on obpa_pkg and the allocator rtl
`timescale 1ns / 1ps

module tb_top;
  import obpa_pkg::*;

  localparam int NUM_BINS    = MAX_BINS_DEF;
  localparam int SCAN_CYCLES = NUM_BINS + 12;
  localparam int RAND_ITEMS  = 1300;
  localparam longint CYCLE_LIMIT = 2500000;

  typedef struct packed {
    logic [BIN_W-1:0]   bin;
    logic               opened;
    logic [COUNT_W-1:0] used;
    status_t            st;
  } placement_t;

  class placement_board;
    logic [WEIGHT_W-1:0] room [NUM_BINS];
    int                  open_cnt;
    logic [WEIGHT_W-1:0] capacity;
    mode_t               mode;
    placement_t          pending_placements [$];
    int                  n_checked;
    int                  n_errors;
    int                  n_opened;
    int                  n_over;
    int                  n_full;

    function new();
      open_cnt  = 0;
      capacity  = CAP_RESET;
      mode      = MODE_FIRST;
      n_checked = 0;
      n_errors  = 0;
      n_opened  = 0;
      n_over    = 0;
      n_full    = 0;
    endfunction

    function void note_item(logic [WEIGHT_W-1:0] w, logic ns);
      placement_t p;
      int         pick;
      int         best;
      int         after;
      p.bin    = '0;
      p.opened = 1'b0;
      p.st     = STAT_OK;
      if (ns)
        open_cnt = 0;
      if (w > capacity) begin
        p.st = STAT_OVER;
      end else begin
        pick = -1;
        best = 0;
        if (mode == MODE_NEXT) begin
          if (open_cnt > 0 && room[open_cnt-1] >= w)
            pick = open_cnt - 1;
        end else begin
          for (int k = 0; k < open_cnt; k++) begin
            if (room[k] < w)
              continue;
            after = int'(room[k]) - int'(w);
            if (mode == MODE_FIRST) begin
              pick = k;
              break;
            end
            if (pick < 0 || (mode == MODE_BEST && after < best) ||
                (mode == MODE_WORST && after > best)) begin
              pick = k;
              best = after;
            end
          end
        end
        if (pick >= 0) begin
          p.bin = pick[BIN_W-1:0];
          room[pick] = room[pick] - w;
        end else if (open_cnt >= NUM_BINS) begin
          p.st = STAT_FULL;
        end else begin
          p.bin = open_cnt[BIN_W-1:0];
          room[open_cnt] = capacity - w;
          open_cnt++;
          p.opened = 1'b1;
        end
      end
      p.used = open_cnt[COUNT_W-1:0];
      pending_placements.push_back(p);
    endfunction

    function void check_placement(logic [BIN_W-1:0] bin, logic opened,
                                  logic [COUNT_W-1:0] used, logic [STATUS_W-1:0] st);
      placement_t exp_p;
      n_checked++;
      if (pending_placements.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("[%0t] unexpected result: bin %0d opened %0b used %0d status %0d",
                   $realtime, bin, opened, used, st);
        return;
      end
      exp_p = pending_placements.pop_front();
      if (exp_p.bin !== bin || exp_p.opened !== opened || exp_p.used !== used ||
          exp_p.st !== st) begin
        n_errors++;
        if (n_errors <= 10)
          $display("[%0t] mismatch: expected bin %0d opened %0b used %0d status %0d, got bin %0d opened %0b used %0d status %0d",
                   $realtime, exp_p.bin, exp_p.opened, exp_p.used, exp_p.st,
                   bin, opened, used, st);
      end
      if (exp_p.opened)
        n_opened++;
      if (exp_p.st == STAT_OVER)
        n_over++;
      if (exp_p.st == STAT_FULL)
        n_full++;
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [WEIGHT_W-1:0] item_weight = '0;
  logic                new_set = 1'b0;
  logic                done;
  logic [BIN_W-1:0]    placed_bin;
  logic                opened_new;
  logic [COUNT_W-1:0]  bins_used;
  logic [STATUS_W-1:0] status;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  placement_board board = new();
  longint cycle_count = 0;
  int     items_sent = 0;
  int     burst_left = 0;
  int     fill_sets = 0;

  always #6 clk = ~clk;

  online_bin_packing_allocator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item_weight(item_weight), .new_set(new_set),
    .done(done), .placed_bin(placed_bin), .opened_new(opened_new),
    .bins_used(bins_used), .status(status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy)
        board.note_item(item_weight, new_set);
      if (done)
        board.check_placement(placed_bin, opened_new, bins_used, status);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(input reg_t r, input logic [31:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (r == REG_CAPACITY)
      board.capacity = v[WEIGHT_W-1:0];
    else
      board.mode = mode_t'(v[MODE_W-1:0]);
  endtask

  task automatic issue_item(input logic [WEIGHT_W-1:0] w, input logic ns);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    item_weight <= w;
    new_set     <= ns;
    start       <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (board.pending_placements.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  function automatic logic [WEIGHT_W-1:0] pick_weight(logic [WEIGHT_W-1:0] cap);
    int c;
    int r;
    c = cap;
    r = $urandom_range(0, 99);
    if (r < 5)
      return '0;
    if (r < 10)
      return cap;
    if (r < 18)
      return (c == 65535) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(c + 1, 65535));
    if (r < 60)
      return 16'($urandom_range(0, c));
    return 16'($urandom_range(0, c / 2));
  endfunction

  task automatic fill_set();
    int c;
    write_reg(REG_CAPACITY, $urandom_range(1, 200));
    write_reg(REG_MODE, MODE_NEXT);
    c = board.capacity;
    // one item per bin until every bin is open, then one more
    for (int i = 0; i <= NUM_BINS; i++)
      issue_item(16'($urandom_range(c / 2 + 1, c)), i == 0);
    drain();
    write_reg(REG_MODE, $urandom_range(MODE_FIRST, MODE_WORST));
    issue_item('0, 1'b0);
    for (int i = 0; i < 6; i++)
      issue_item(pick_weight(board.capacity), 1'b0);
    drain();
    fill_sets++;
  endtask

  initial begin
    int phase_no;
    int n;
    int r;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset config: capacity 10, first fit
    issue_item(16'd3, 1'b1);
    issue_item(16'd0, 1'b0);
    issue_item(16'd10, 1'b0);
    issue_item(16'd11, 1'b0);
    issue_item(16'd7, 1'b0);
    issue_item(16'hFFFF, 1'b0);
    issue_item(16'd0, 1'b1);
    drain();
    write_reg(REG_MODE, MODE_BEST);
    issue_item(16'd6, 1'b1);
    issue_item(16'd5, 1'b0);
    issue_item(16'd4, 1'b0);
    issue_item(16'd3, 1'b0);
    issue_item(16'd1, 1'b0);
    drain();
    // policy change with bins still open
    write_reg(REG_MODE, MODE_WORST);
    issue_item(16'd1, 1'b0);
    issue_item(16'd2, 1'b0);
    drain();
    // capacity change with bins still open
    write_reg(REG_MODE, MODE_NEXT);
    write_reg(REG_CAPACITY, 20);
    issue_item(16'd15, 1'b0);
    issue_item(16'd20, 1'b0);
    issue_item(16'd0, 1'b1);
    issue_item(16'd21, 1'b0);
    drain();
    write_reg(REG_CAPACITY, 1);
    write_reg(REG_MODE, MODE_FIRST);
    issue_item(16'd1, 1'b1);
    issue_item(16'd1, 1'b0);
    issue_item(16'd0, 1'b0);
    issue_item(16'd2, 1'b0);
    drain();
    write_reg(REG_CAPACITY, 65535);
    write_reg(REG_MODE, MODE_WORST);
    issue_item(16'hFFFF, 1'b1);
    issue_item(16'h8000, 1'b0);
    issue_item(16'd0, 1'b0);
    drain();

    phase_no = 0;
    while (items_sent < RAND_ITEMS) begin
      if (phase_no % 15 == 7) begin
        fill_set();
      end else begin
        r = $urandom_range(0, 2);
        if (r != 2) begin
          case ($urandom_range(0, 4))
            0: write_reg(REG_CAPACITY, 1);
            1: write_reg(REG_CAPACITY, 65535);
            2: write_reg(REG_CAPACITY, $urandom_range(2, 16));
            3: write_reg(REG_CAPACITY, $urandom_range(17, 1000));
            default: write_reg(REG_CAPACITY, $urandom_range(1, 65535));
          endcase
        end
        if (r != 1)
          write_reg(REG_MODE, $urandom_range(MODE_NEXT, MODE_WORST));
        n = $urandom_range(15, 60);
        for (int i = 0; i < n; i++)
          issue_item(pick_weight(board.capacity),
                     (i == 0) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 29) == 0));
        drain();
      end
      phase_no++;
    end

    drain();
    repeat (SCAN_CYCLES) @(posedge clk);
    $display("run covered %0d items in %0d phases and %0d fill-to-exhaustion sets",
             items_sent, phase_no, fill_sets);
    $display("results checked %0d: %0d opened a bin, %0d overweight, %0d no bin left, %0d errors",
             board.n_checked, board.n_opened, board.n_over, board.n_full, board.n_errors);
    if (board.n_errors == 0 && board.pending_placements.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
